// ===== src/rbst_pkg.sv =====
// Package for the ray/box slab test: default widths and divider staging.
// No dependencies; used by every module of the block.
package rbst_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int DIR_WIDTH_DEF   = 16;
    // quotient bits resolved per divider pipeline stage
    localparam int DIV_STEPS       = 4;
    localparam int TOL_WIDTH       = 16;
    localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd66;
endpackage

// ===== src/ray_box_slab_test.sv =====
// Ray versus axis-aligned box slab test, fully pipelined.
// Pipeline depth is set by the six pipelined slab dividers (4 quotient bits per
// stage). Throughput: one item per cycle when no result is held under stall.
// Synchronous active-low reset empties the pipeline and sets tolerance to 66;
// payload registers are not reset. The whole pipeline holds while a result
// waits under stall.
module ray_box_slab_test #(
    parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
    parameter int DIR_WIDTH   = rbst_pkg::DIR_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input item channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_box_min_x,
    input  logic signed [COORD_WIDTH-1:0]       i_box_min_y,
    input  logic signed [COORD_WIDTH-1:0]       i_box_min_z,
    input  logic signed [COORD_WIDTH-1:0]       i_box_max_x,
    input  logic signed [COORD_WIDTH-1:0]       i_box_max_y,
    input  logic signed [COORD_WIDTH-1:0]       i_box_max_z,
    input  logic signed [COORD_WIDTH-1:0]       i_ray_origin_x,
    input  logic signed [COORD_WIDTH-1:0]       i_ray_origin_y,
    input  logic signed [COORD_WIDTH-1:0]       i_ray_origin_z,
    input  logic signed [DIR_WIDTH-1:0]         i_ray_dir_x,
    input  logic signed [DIR_WIDTH-1:0]         i_ray_dir_y,
    input  logic signed [DIR_WIDTH-1:0]         i_ray_dir_z,
    // result item channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit,
    // tolerance register write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rbst_pkg::TOL_WIDTH-1:0]      i_cfg_tolerance
);
    import rbst_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int DW      = DIR_WIDTH;
    // divider latency; side data is delayed to match
    localparam int DIV_LAT = (CW + 1 + DIV_STEPS - 1) / DIV_STEPS + 2;

    logic                  w_en;
    logic [TOL_WIDTH-1:0]  r_tol;

    logic [2:0][CW-1:0]    w_lo, w_hi, w_org;
    logic [2:0][DW-1:0]    w_dir;
    logic [2:0][CW:0]      w_mag_lo, w_mag_hi;
    logic [2:0]            w_neg_lo, w_neg_hi, w_dz;
    logic [2:0][DW-1:0]    w_dmag;
    logic                  w_miss;
    logic                  r_vld_f;
    logic [2:0][CW-1:0]    w_t1, w_t2;

    // side line alongside the dividers
    logic                  r_sd_vld  [DIV_LAT];
    logic [2:0]            r_sd_dz   [DIV_LAT];
    logic                  r_sd_miss [DIV_LAT];

    // the whole pipe advances unless the finished result is being held
    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)         r_tol <= TOL_RESET;
        else if (i_cfg_valid) r_tol <= i_cfg_tolerance;
    end

    assign w_lo  = {i_box_min_z, i_box_min_y, i_box_min_x};
    assign w_hi  = {i_box_max_z, i_box_max_y, i_box_max_x};
    assign w_org = {i_ray_origin_z, i_ray_origin_y, i_ray_origin_x};
    assign w_dir = {i_ray_dir_z, i_ray_dir_y, i_ray_dir_x};

    rbst_front #(.CW(CW), .DW(DW)) u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo     (w_lo),
        .i_hi     (w_hi),
        .i_org    (w_org),
        .i_dir    (w_dir),
        .o_mag_lo (w_mag_lo),
        .o_mag_hi (w_mag_hi),
        .o_neg_lo (w_neg_lo),
        .o_neg_hi (w_neg_hi),
        .o_dmag   (w_dmag),
        .o_dz     (w_dz),
        .o_miss   (w_miss)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)  r_vld_f <= 1'b0;
        else if (w_en) r_vld_f <= i_valid;
    end

    // two slab dividers per axis: minimum and maximum corner
    for (genvar a = 0; a < 3; a++) begin : g_axis
        rbst_div #(.CW(CW), .DW(DW)) u_div_lo (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mag  (w_mag_lo[a]),
            .i_neg  (w_neg_lo[a]),
            .i_dmag (w_dmag[a]),
            .o_t    (w_t1[a])
        );
        rbst_div #(.CW(CW), .DW(DW)) u_div_hi (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mag  (w_mag_hi[a]),
            .i_neg  (w_neg_hi[a]),
            .i_dmag (w_dmag[a]),
            .o_t    (w_t2[a])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd_dz[0]   <= w_dz;
            r_sd_miss[0] <= w_miss;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_sd_dz[i]   <= r_sd_dz[i-1];
                r_sd_miss[i] <= r_sd_miss[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) r_sd_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_sd_vld[0] <= r_vld_f;
            for (int i = 1; i < DIV_LAT; i++) r_sd_vld[i] <= r_sd_vld[i-1];
        end
    end

    rbst_reduce #(.CW(CW)) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_sd_vld[DIV_LAT-1]),
        .i_t1    (w_t1),
        .i_t2    (w_t2),
        .i_dz    (r_sd_dz[DIV_LAT-1]),
        .i_miss  (r_sd_miss[DIV_LAT-1]),
        .i_tol   (r_tol),
        .o_valid (o_valid),
        .o_hit   (o_hit)
    );
endmodule

// ===== src/rbst_front.sv =====
// Front stage: corner-origin differences, magnitudes, signs, zero-direction check.
// Depends on rbst_pkg.
module rbst_front #(
    parameter int CW = rbst_pkg::COORD_WIDTH_DEF,
    parameter int DW = rbst_pkg::DIR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [2:0][CW-1:0]   i_lo,
    input  logic [2:0][CW-1:0]   i_hi,
    input  logic [2:0][CW-1:0]   i_org,
    input  logic [2:0][DW-1:0]   i_dir,
    output logic [2:0][CW:0]     o_mag_lo,
    output logic [2:0][CW:0]     o_mag_hi,
    output logic [2:0]           o_neg_lo,
    output logic [2:0]           o_neg_hi,
    output logic [2:0][DW-1:0]   o_dmag,
    output logic [2:0]           o_dz,
    output logic                 o_miss
);
    import rbst_pkg::*;

    logic [2:0][CW:0]   n_mag_lo, n_mag_hi;
    logic [2:0]         n_neg_lo, n_neg_hi, n_dz, n_axmiss;
    logic [2:0][DW-1:0] n_dmag;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic signed [CW:0] dlo, dhi;
            logic               dneg;
            dlo  = $signed({i_lo[a][CW-1], i_lo[a]}) - $signed({i_org[a][CW-1], i_org[a]});
            dhi  = $signed({i_hi[a][CW-1], i_hi[a]}) - $signed({i_org[a][CW-1], i_org[a]});
            dneg = i_dir[a][DW-1];
            n_mag_lo[a] = dlo[CW] ? (~dlo + 1'b1) : dlo;
            n_mag_hi[a] = dhi[CW] ? (~dhi + 1'b1) : dhi;
            n_neg_lo[a] = dlo[CW] ^ dneg;
            n_neg_hi[a] = dhi[CW] ^ dneg;
            n_dmag[a]   = dneg ? (~i_dir[a] + 1'b1) : i_dir[a];
            n_dz[a]     = (i_dir[a] == '0);
            // origin outside slab with no motion along the axis
            n_axmiss[a] = n_dz[a] && ($signed(i_org[a]) < $signed(i_lo[a])
                                   || $signed(i_org[a]) > $signed(i_hi[a]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mag_lo <= n_mag_lo;
            o_mag_hi <= n_mag_hi;
            o_neg_lo <= n_neg_lo;
            o_neg_hi <= n_neg_hi;
            o_dmag   <= n_dmag;
            o_dz     <= n_dz;
            o_miss   <= |n_axmiss;
        end
    end
endmodule

// ===== src/rbst_div.sv =====
// Pipelined restoring divider: (mag << (DW-1)) / dmag, signed, saturated to CW bits.
// Depends on rbst_pkg (DIV_STEPS); registered at input, each stage and output.
module rbst_div #(
    parameter int CW = rbst_pkg::COORD_WIDTH_DEF,
    parameter int DW = rbst_pkg::DIR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [CW:0]          i_mag,
    input  logic                 i_neg,
    input  logic [DW-1:0]        i_dmag,
    output logic signed [CW-1:0] o_t
);
    import rbst_pkg::*;

    localparam int QW = CW + 1;
    localparam int NW = CW + DW;
    localparam int NS = (QW + DIV_STEPS - 1) / DIV_STEPS;

    logic [NW-1:0]   w_num;
    logic [DW-2:0]   w_top;
    logic [DW-1:0]   r_rem [0:NS];
    logic [QW-1:0]   r_w   [0:NS];
    logic [DW-1:0]   r_d   [0:NS];
    logic            r_ovf [0:NS];
    logic            r_neg [0:NS];
    logic signed [CW-1:0] n_t;

    assign w_num = {i_mag, {(DW-1){1'b0}}};
    assign w_top = w_num[NW-1 -: DW-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf[0] <= ({1'b0, w_top} >= i_dmag);
            r_rem[0] <= {1'b0, w_top};
            r_w[0]   <= w_num[QW-1:0];
            r_d[0]   <= i_dmag;
            r_neg[0] <= i_neg;
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [DW-1:0] n_rem;
        logic [QW-1:0] n_w;
        always_comb begin
            logic [DW:0] r2;
            n_rem = r_rem[s];
            n_w   = r_w[s];
            for (int k = 0; k < DIV_STEPS; k++) begin
                if (s * DIV_STEPS + k < QW) begin
                    r2  = {n_rem, n_w[QW-1]};
                    n_w = {n_w[QW-2:0], 1'b0};
                    if (r2 >= {1'b0, r_d[s]}) begin
                        r2     = r2 - {1'b0, r_d[s]};
                        n_w[0] = 1'b1;
                    end
                    n_rem = r2[DW-1:0];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem;
                r_w[s+1]   <= n_w;
                r_d[s+1]   <= r_d[s];
                r_ovf[s+1] <= r_ovf[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    always_comb begin
        logic [QW-1:0] lim;
        lim = {2'b01, {(CW-1){1'b0}}};
        if (r_neg[NS]) begin
            if (r_ovf[NS] || r_w[NS] > lim) n_t = {1'b1, {(CW-1){1'b0}}};
            else                            n_t = -$signed(r_w[NS][CW-1:0]);
        end else begin
            if (r_ovf[NS] || r_w[NS] >= lim) n_t = {1'b0, {(CW-1){1'b1}}};
            else                             n_t = r_w[NS][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_t <= n_t;
    end
endmodule

// ===== src/rbst_reduce.sv =====
// Back end: per-axis near/far, reduction over axes, tolerance compare, output register.
// Depends on rbst_pkg. Three register stages; the last drives the result.
module rbst_reduce #(
    parameter int CW = rbst_pkg::COORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [2:0][CW-1:0]              i_t1,
    input  logic [2:0][CW-1:0]              i_t2,
    input  logic [2:0]                      i_dz,
    input  logic                            i_miss,
    input  logic [rbst_pkg::TOL_WIDTH-1:0]  i_tol,
    output logic                            o_valid,
    output logic                            o_hit
);
    import rbst_pkg::*;

    localparam int EW = CW + TOL_WIDTH + 2;
    localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};

    logic signed [CW-1:0] r_tn [3], r_tf [3];
    logic signed [CW-1:0] n_tn [3], n_tf [3];
    logic                 r_miss_a, r_miss_b, r_vld_a, r_vld_b;
    logic signed [CW-1:0] r_near, r_far, n_near, n_far;
    logic signed [EW-1:0] w_far, w_near, w_eps;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            logic lt;
            lt = $signed(i_t1[a]) < $signed(i_t2[a]);
            n_tn[a] = i_dz[a] ? T_MIN : (lt ? i_t1[a] : i_t2[a]);
            n_tf[a] = i_dz[a] ? T_MAX : (lt ? i_t2[a] : i_t1[a]);
        end
        n_near = r_tn[0];
        n_far  = r_tf[0];
        for (int a = 1; a < 3; a++) begin
            if (r_tn[a] > n_near) n_near = r_tn[a];
            if (r_tf[a] < n_far)  n_far  = r_tf[a];
        end
    end

    assign w_far  = EW'(r_far);
    assign w_near = EW'(r_near);
    assign w_eps  = $signed({{(EW-TOL_WIDTH){1'b0}}, i_tol});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tn     <= n_tn;
            r_tf     <= n_tf;
            r_miss_a <= i_miss;
            r_near   <= n_near;
            r_far    <= n_far;
            r_miss_b <= r_miss_a;
            o_hit    <= !(r_miss_b || (w_far < -w_eps) || (w_near > w_far + w_eps));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            o_valid <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            o_valid <= r_vld_b;
        end
    end
endmodule

// ===== src/rbst_checker.sv =====
// Port-level checker for ray_box_slab_test, bound to the top level.
// Imports rbst_pkg; no item of it is used here.
module rbst_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic                               o_hit,
    input logic                               o_cfg_ready
);
    import rbst_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit))
        else $error("held result changed");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("tolerance write refused");
endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_hit       (o_hit),
    .o_cfg_ready (o_cfg_ready)
);

// ===== test/ray_box_slab_test_test.sv =====
// Testbench for ray_box_slab_test: random and directed ray/box queries checked
// against an in-bench slab predictor. Depends on rbst_pkg and the block RTL.
`timescale 1ns / 100ps

module ray_box_slab_test_test;
    import rbst_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int DW = DIR_WIDTH_DEF;
    localparam int LATENCY = (CW + 4) / 4 + 6;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [CW-1:0] min_x, min_y, min_z;
        logic signed [CW-1:0] max_x, max_y, max_z;
        logic signed [CW-1:0] org_x, org_y, org_z;
        logic signed [DW-1:0] dir_x, dir_y, dir_z;
    } query_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [TOL_WIDTH-1:0] i_cfg_tolerance = '0;
    logic o_stall, o_valid, o_hit, o_cfg_ready;
    query_t cur_q = '0;

    ray_box_slab_test u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_box_min_x(cur_q.min_x), .i_box_min_y(cur_q.min_y), .i_box_min_z(cur_q.min_z),
        .i_box_max_x(cur_q.max_x), .i_box_max_y(cur_q.max_y), .i_box_max_z(cur_q.max_z),
        .i_ray_origin_x(cur_q.org_x), .i_ray_origin_y(cur_q.org_y),
        .i_ray_origin_z(cur_q.org_z),
        .i_ray_dir_x(cur_q.dir_x), .i_ray_dir_y(cur_q.dir_y), .i_ray_dir_z(cur_q.dir_z),
        .o_valid(o_valid), .i_stall(i_stall), .o_hit(o_hit),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_tolerance(i_cfg_tolerance)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: our own copy of the tolerance register
    logic [TOL_WIDTH-1:0] tol_shadow = TOL_RESET;

    query_t pending_queries[$];
    logic   expected_hits[$];
    int     sender_idle_pct = 0;
    int     receiver_stall_pct = 0;
    int     hold_off = 0;       // cycles of forced receiver stall left
    int     errors = 0;
    longint cycles = 0;
    logic   in_taken = 1'b0;    // input item accepted at the last rising edge

    // Slab distance: exact diff, scaled by 2^(DW-1), truncating divide, saturated.
    function automatic longint slab_dist(longint diff, longint dir);
        logic   neg;
        longint mag, dmag, lim, quo;
        neg  = (diff < 0) != (dir < 0);
        mag  = diff < 0 ? -diff : diff;
        dmag = dir < 0 ? -dir : dir;
        lim  = longint'(1) << (CW - 1);
        // mag < 2^32, shifted by 15 stays well inside 64 bits
        quo  = (mag << (DW - 1)) / dmag;
        if (neg) begin
            if (quo > lim) quo = lim;
            return -quo;
        end
        if (quo > lim - 1) quo = lim - 1;
        return quo;
    endfunction

    function automatic logic predict_hit(query_t q);
        longint lo[3], hi[3], org[3], dir[3];
        longint near_t, far_t, t1, t2, eps;
        logic   miss;
        lo  = '{q.min_x, q.min_y, q.min_z};
        hi  = '{q.max_x, q.max_y, q.max_z};
        org = '{q.org_x, q.org_y, q.org_z};
        dir = '{q.dir_x, q.dir_y, q.dir_z};
        near_t = -(longint'(1) << (CW - 1));
        far_t  = (longint'(1) << (CW - 1)) - 1;
        eps    = tol_shadow;
        miss   = 1'b0;
        for (int a = 0; a < 3; a++) begin
            if (dir[a] == 0) begin
                // parallel axis: origin must sit inside the slab
                if (org[a] < lo[a] || org[a] > hi[a]) miss = 1'b1;
            end else begin
                t1 = slab_dist(lo[a] - org[a], dir[a]);
                t2 = slab_dist(hi[a] - org[a], dir[a]);
                if (t1 > t2) begin
                    longint sw;
                    sw = t1; t1 = t2; t2 = sw;
                end
                if (t1 > near_t) near_t = t1;
                if (t2 < far_t) far_t = t2;
            end
        end
        if (far_t < -eps) miss = 1'b1;
        if (near_t > far_t + eps) miss = 1'b1;
        return ~miss;
    endfunction

    // Driver: offers the head of the queue, random sender gaps; the current
    // item is replaced only once it has been taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (pending_queries.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                cur_q   <= pending_queries.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, or a forced hold-off counted down here
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_stall  <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Monitor: predict on input acceptance, check on output acceptance
    always @(posedge i_clk) begin
        cycles   <= cycles + 1;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) expected_hits.push_back(predict_hit(cur_q));
            if (o_valid && !i_stall) begin
                if (expected_hits.size() == 0) begin
                    $display("%0t: result with none expected: hit=%0b", $time, o_hit);
                    errors <= errors + 1;
                end else begin
                    logic want;
                    want = expected_hits.pop_front();
                    if (o_hit !== want) begin
                        $display("%0t: hit mismatch: expected %0b actual %0b",
                                 $time, want, o_hit);
                        errors <= errors + 1;
                    end
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_box_slab_test_test: done, errors");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return {$urandom()};
            1: return $urandom_range(1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'(int'($urandom_range(2 << 16)) - (1 << 16));
        endcase
    endfunction

    function automatic logic signed [DW-1:0] rnd_dir();
        case ($urandom_range(6))
            0: return '0;
            1: return $urandom_range(1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            2: return DW'(int'($urandom_range(8)) - 4);
            default: return DW'($urandom());
        endcase
    endfunction

    // Random origin, direction and box corners; about one box in ten is inverted on x
    function automatic query_t rnd_query();
        query_t q;
        logic signed [CW-1:0] a, b;
        q.org_x = rnd_coord(); q.org_y = rnd_coord(); q.org_z = rnd_coord();
        q.dir_x = rnd_dir();   q.dir_y = rnd_dir();   q.dir_z = rnd_dir();
        a = rnd_coord(); b = rnd_coord();
        q.min_x = (a < b) ? a : b; q.max_x = (a < b) ? b : a;
        a = rnd_coord(); b = rnd_coord();
        q.min_y = (a < b) ? a : b; q.max_y = (a < b) ? b : a;
        a = rnd_coord(); b = rnd_coord();
        q.min_z = (a < b) ? a : b; q.max_z = (a < b) ? b : a;
        if ($urandom_range(9) == 0) begin
            // inverted box on one axis
            a = q.min_x; q.min_x = q.max_x; q.max_x = a;
        end
        return q;
    endfunction

    task automatic wait_idle();
        while (pending_queries.size() > 0 || i_valid || expected_hits.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TOL_WIDTH-1:0] v);
        @(negedge i_clk);
        i_cfg_valid     <= 1'b1;
        i_cfg_tolerance <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tol_shadow = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n, int idle, int stall);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        repeat (n) pending_queries.push_back(rnd_query());
        wait_idle();
    endtask

    initial begin
        query_t q;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: unit box around origin variants
        q = '{min_x: -32'sh10000, min_y: -32'sh10000, min_z: -32'sh10000,
              max_x: 32'sh10000, max_y: 32'sh10000, max_z: 32'sh10000,
              org_x: 0, org_y: 0, org_z: 0, dir_x: 0, dir_y: 0, dir_z: 0};
        pending_queries.push_back(q);           // all-zero direction, inside: hit
        q.org_x = 32'sh20000;
        pending_queries.push_back(q);           // zero direction, outside: miss
        q.dir_x = 16'sh8000;
        pending_queries.push_back(q);           // most negative direction
        q.dir_x = 16'sh7fff;
        pending_queries.push_back(q);           // pointing away: miss
        q.dir_x = 16'sh0001;
        q.org_x = 32'sh80000000;
        pending_queries.push_back(q);           // saturating distances
        q.min_x = 32'sh7fffffff; q.max_x = 32'sh80000000;
        pending_queries.push_back(q);           // inverted box, extreme corners
        q.dir_x = 0;
        pending_queries.push_back(q);           // inverted box, parallel axis
        q = '{min_x: 32'sh80000000, min_y: 32'sh80000000, min_z: 32'sh80000000,
              max_x: 32'sh7fffffff, max_y: 32'sh7fffffff, max_z: 32'sh7fffffff,
              org_x: 32'sh7fffffff, org_y: 32'sh80000000, org_z: 0,
              dir_x: 16'sh8000, dir_y: 16'sh7fff, dir_z: 16'sh0001};
        pending_queries.push_back(q);
        // box just behind origin, within and beyond tolerance
        q = '{min_x: -32'sh100, min_y: -32'sh100, min_z: -32'sh100,
              max_x: -32'sd40, max_y: 32'sh100, max_z: 32'sh100,
              org_x: 0, org_y: 0, org_z: 0, dir_x: 16'sh7fff, dir_y: 0, dir_z: 0};
        pending_queries.push_back(q);
        q.max_x = -32'sd70;
        pending_queries.push_back(q);
        wait_idle();

        run_random(150, 0, 0);
        write_tolerance(16'd0);
        run_random(150, 76, 0);
        write_tolerance(16'hffff);
        run_random(150, 0, 76);
        write_tolerance(16'($urandom()));
        run_random(150, 19, 19);

        // Long receiver hold-off while the sender keeps offering
        write_tolerance(TOL_RESET);
        hold_off = 200;
        run_random(100, 0, 0);

        if (errors == 0) begin
            $display("ray_box_slab_test_test: done, clean");
        end else begin
            $display("ray_box_slab_test_test: done, errors");
        end
        $finish;
    end
endmodule
